>>> rtl/greedy_box_tracker_assert.svh
// Assertion macros used by the greedy box tracker datapath.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef GREEDY_BOX_TRACKER_ASSERT_SVH
`define GREEDY_BOX_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GBT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gbt assertion failed");
`define GBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbt assertion failed");
`else
`define GBT_ASSERT_NEVER(label, clk, rst_n, cond)
`define GBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/gbt_pkg.sv
// Package of the greedy box tracker: payload types, operation codes,
// command and status structs and small arithmetic helpers. No dependencies.
package gbt_pkg;

  localparam int MAX_TRACKS_DEF = 16;
  localparam int MAX_DETS_DEF   = 32;

  localparam logic [8:0] THR_RESET   = 9'd77;
  localparam logic [7:0] LIMIT_RESET = 8'd30;
  localparam logic [7:0] MISS_MAX    = 8'd255;

  localparam logic signed [29:0] EMA_NEW   = 30'sd179;
  localparam logic signed [29:0] EMA_OLD   = 30'sd77;
  localparam logic signed [29:0] EMA_ROUND = 30'sd128;

  typedef enum logic {
    CFG_THRESHOLD  = 1'b0,
    CFG_MISS_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              is_detection;
    logic              frame_end;
    logic signed [19:0] det_x;
    logic signed [19:0] det_y;
    logic [18:0]       det_width;
    logic [18:0]       det_height;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] track_x;
    logic signed [19:0] track_y;
    logic [18:0]       track_width;
    logic [18:0]       track_height;
    logic [31:0]       track_ident;
    logic              last_track;
  } out_item_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [18:0]       w;
    logic [18:0]       h;
  } det_ent_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [18:0]       w;
    logic [18:0]       h;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic [7:0]        miss;
    logic [31:0]       label;
  } trk_ent_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_PR_RD, OP_PR_WR,
    OP_M_TRD, OP_M_TLAT, OP_M_DRD, OP_M_DIF, OP_M_SQ, OP_M_CMP, OP_M_CHK,
    OP_O_LAT, OP_O_MUL, OP_O_UNI, OP_O_THR, OP_O_CMP, OP_A_EMA, OP_M_NXT,
    OP_N_DRD, OP_N_WR, OP_P_RD, OP_P_WR, OP_P_FIN, OP_E_RD, OP_E_LD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic clr;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic t_end;
    logic d_end;
    logic d_taken;
    logic full;
    logic found;
    logic ok;
    logic out_free;
  } status_t;

  function automatic logic signed [21:0] sx22(input logic signed [19:0] v);
    return {{2{v[19]}}, v};
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
    if (v > 22'sd524287) return 20'sd524287;
    if (v < -22'sd524288) return -20'sd524288;
    return v[19:0];
  endfunction

  // doubled centre: 2*x + w
  function automatic logic signed [21:0] centre2(input logic signed [19:0] x,
                                                 input logic [18:0] w);
    return {x[19], x, 1'b0} + {3'b000, w};
  endfunction

  function automatic logic [21:0] absdiff(input logic signed [21:0] a,
                                          input logic signed [21:0] b);
    logic [22:0] d;
    d = {a[21], a} - {b[21], b};
    return d[22] ? 22'(-d) : d[21:0];
  endfunction

  function automatic logic [18:0] overlap1d(input logic signed [19:0] a0,
                                            input logic [18:0] al,
                                            input logic signed [19:0] b0,
                                            input logic [18:0] bl);
    logic signed [19:0] lo;
    logic signed [20:0] ae;
    logic signed [20:0] be;
    logic signed [20:0] hi;
    logic signed [20:0] lo21;
    logic [20:0]        diff;
    lo   = (a0 > b0) ? a0 : b0;
    ae   = {a0[19], a0} + {2'b00, al};
    be   = {b0[19], b0} + {2'b00, bl};
    hi   = (ae < be) ? ae : be;
    lo21 = {lo[19], lo};
    diff = hi - lo21;
    return (hi > lo21) ? diff[18:0] : 19'd0;
  endfunction

endpackage

>>> rtl/gbt_ctrl.sv
// Sequencer of the greedy box tracker: walks load, predict, match, open,
// prune and emit phases. Uses gbt_pkg; drives gbt_datapath by command.
module gbt_ctrl import gbt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    frame_end,
  input  status_t sts,
  output logic    in_ready,
  output cmd_t    cmd
);

  op_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = state_r;
    cmd.clr   = 1'b0;
    cmd.load  = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      OP_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (frame_end) begin
            cmd.clr   = 1'b1;
            state_nxt = OP_PR_RD;
          end
        end
      end
      OP_PR_RD: begin
        if (sts.t_end) begin
          cmd.clr   = 1'b1;
          state_nxt = OP_M_TRD;
        end else begin
          state_nxt = OP_PR_WR;
        end
      end
      OP_PR_WR:  state_nxt = OP_PR_RD;
      OP_M_TRD: begin
        if (sts.t_end) begin
          cmd.clr   = 1'b1;
          state_nxt = OP_N_DRD;
        end else begin
          state_nxt = OP_M_TLAT;
        end
      end
      OP_M_TLAT: state_nxt = OP_M_DRD;
      OP_M_DRD: begin
        if (sts.d_end) state_nxt = OP_M_CHK;
        else if (!sts.d_taken) state_nxt = OP_M_DIF;
      end
      OP_M_DIF:  state_nxt = OP_M_SQ;
      OP_M_SQ:   state_nxt = OP_M_CMP;
      OP_M_CMP:  state_nxt = OP_M_DRD;
      OP_M_CHK:  state_nxt = sts.found ? OP_O_LAT : OP_M_NXT;
      OP_O_LAT:  state_nxt = OP_O_MUL;
      OP_O_MUL:  state_nxt = OP_O_UNI;
      OP_O_UNI:  state_nxt = OP_O_THR;
      OP_O_THR:  state_nxt = OP_O_CMP;
      OP_O_CMP:  state_nxt = sts.ok ? OP_A_EMA : OP_M_NXT;
      OP_A_EMA:  state_nxt = OP_M_NXT;
      OP_M_NXT:  state_nxt = OP_M_TRD;
      OP_N_DRD: begin
        if (sts.d_end || sts.full) begin
          cmd.clr   = 1'b1;
          state_nxt = OP_P_RD;
        end else if (!sts.d_taken) begin
          state_nxt = OP_N_WR;
        end
      end
      OP_N_WR:   state_nxt = OP_N_DRD;
      OP_P_RD:   state_nxt = sts.t_end ? OP_P_FIN : OP_P_WR;
      OP_P_WR:   state_nxt = OP_P_RD;
      OP_P_FIN: begin
        cmd.clr   = 1'b1;
        state_nxt = OP_E_RD;
      end
      OP_E_RD: begin
        if (sts.t_end) state_nxt = OP_IDLE;
        else if (sts.out_free) state_nxt = OP_E_LD;
      end
      OP_E_LD:   state_nxt = OP_E_RD;
      default:   state_nxt = OP_IDLE;
    endcase
  end

endmodule

>>> rtl/gbt_datapath.sv
// Datapath of the greedy box tracker: detection and track stores, counters,
// distance, overlap and velocity arithmetic, result register. Uses gbt_pkg and the assertion header.
`include "greedy_box_tracker_assert.svh"
module gbt_datapath import gbt_pkg::*; #(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int MAX_DETS   = MAX_DETS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  input  logic [8:0] thr,
  input  logic [7:0] limit,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output status_t   sts
);

  localparam int TIW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CTW = $clog2(MAX_TRACKS + 1);
  localparam int DIW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int CDW = $clog2(MAX_DETS + 1);

  det_ent_t det_mem [MAX_DETS];
  trk_ent_t trk_mem [MAX_TRACKS];
  det_ent_t det_rd_r;
  trk_ent_t trk_rd_r;

  logic [CTW-1:0] t_r, t_nxt, n_r, n_nxt, trk_cnt_r, trk_cnt_nxt;
  logic [CDW-1:0] d_r, d_nxt, det_cnt_r, det_cnt_nxt;
  logic [MAX_DETS-1:0] taken_r, taken_nxt;
  logic [DIW-1:0] best_d_r;
  logic [44:0]    best_r;
  logic           found_r, found_nxt;
  logic [31:0]    next_label_r, next_label_nxt;
  logic           out_valid_r, out_valid_nxt;

  trk_ent_t tcur_r;
  det_ent_t dcur_r;
  logic [21:0] ex_r, ey_r;
  logic [43:0] sqx_r, sqy_r;
  logic [44:0] dist2;
  logic [18:0] ox_r, oy_r;
  logic [37:0] inter_r, at_r, ad_r;
  logic [38:0] uni_r;
  logic [47:0] thu_r;
  logic        uz_r;
  logic signed [20:0] dispx_r, dispy_r;
  logic signed [29:0] p1x_r, p2x_r, p1y_r, p2y_r;
  logic signed [29:0] sx, sy;
  out_item_t out_r;

  logic [DIW-1:0] det_raddr;
  logic           trk_we;
  logic [TIW-1:0] trk_waddr;
  trk_ent_t       trk_wdata;
  logic           det_we;
  det_ent_t       det_wdata;
  logic [CTW-1:0] t_inc;

  assign t_inc = t_r + CTW'(1);
  assign dist2 = 45'(sqx_r) + 45'(sqy_r);
  assign sx    = p1x_r + p2x_r + EMA_ROUND;
  assign sy    = p1y_r + p2y_r + EMA_ROUND;

  assign sts.t_end    = (t_r >= trk_cnt_r);
  assign sts.d_end    = (d_r >= det_cnt_r);
  assign sts.d_taken  = taken_r[d_r[DIW-1:0]];
  assign sts.full     = (trk_cnt_r >= CTW'(MAX_TRACKS));
  assign sts.found    = found_r;
  assign sts.ok       = uz_r ? (thr == 9'd0) : ({2'b00, inter_r, 8'd0} >= thu_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign det_we    = cmd.load && in_data.is_detection && (det_cnt_r < CDW'(MAX_DETS));
  assign det_wdata = '{x: in_data.det_x, y: in_data.det_y,
                       w: in_data.det_width, h: in_data.det_height};
  assign det_raddr = (cmd.op == OP_M_CHK) ? best_d_r : d_r[DIW-1:0];

  // track store write port
  always_comb begin
    trk_we    = 1'b0;
    trk_waddr = t_r[TIW-1:0];
    trk_wdata = trk_rd_r;
    case (cmd.op)
      OP_PR_WR: begin
        trk_we       = 1'b1;
        trk_wdata.x  = sat20(sx22(trk_rd_r.x) + sx22(trk_rd_r.vx));
        trk_wdata.y  = sat20(sx22(trk_rd_r.y) + sx22(trk_rd_r.vy));
        trk_wdata.miss = (trk_rd_r.miss == MISS_MAX) ? MISS_MAX : trk_rd_r.miss + 8'd1;
      end
      OP_A_EMA: begin
        trk_we    = 1'b1;
        trk_wdata = '{x: dcur_r.x, y: dcur_r.y, w: dcur_r.w, h: dcur_r.h,
                      vx: sat20(sx[29:8]), vy: sat20(sy[29:8]),
                      miss: 8'd0, label: tcur_r.label};
      end
      OP_N_WR: begin
        trk_we    = 1'b1;
        trk_waddr = trk_cnt_r[TIW-1:0];
        trk_wdata = '{x: det_rd_r.x, y: det_rd_r.y, w: det_rd_r.w, h: det_rd_r.h,
                      vx: 20'sd0, vy: 20'sd0, miss: 8'd0, label: next_label_r};
      end
      OP_P_WR: begin
        trk_we    = (trk_rd_r.miss <= limit);
        trk_waddr = n_r[TIW-1:0];
      end
      default: ;
    endcase
  end

  // counters and flags
  always_comb begin
    t_nxt          = t_r;
    d_nxt          = d_r;
    n_nxt          = n_r;
    trk_cnt_nxt    = trk_cnt_r;
    det_cnt_nxt    = det_cnt_r;
    taken_nxt      = taken_r;
    found_nxt      = found_r;
    next_label_nxt = next_label_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (det_we) begin
      taken_nxt[det_cnt_r[DIW-1:0]] = 1'b0;
      det_cnt_nxt = det_cnt_r + CDW'(1);
    end
    case (cmd.op)
      OP_PR_WR, OP_M_NXT: t_nxt = t_inc;
      OP_M_TLAT: begin
        d_nxt     = '0;
        found_nxt = 1'b0;
      end
      OP_M_DRD, OP_N_DRD: begin
        if (!sts.d_end && sts.d_taken) d_nxt = d_r + CDW'(1);
      end
      OP_M_CMP: begin
        d_nxt = d_r + CDW'(1);
        if (dist2 < best_r) found_nxt = 1'b1;
      end
      OP_A_EMA: taken_nxt[best_d_r] = 1'b1;
      OP_N_WR: begin
        d_nxt          = d_r + CDW'(1);
        trk_cnt_nxt    = trk_cnt_r + CTW'(1);
        next_label_nxt = next_label_r + 32'd1;
      end
      OP_P_WR: begin
        t_nxt = t_inc;
        if (trk_we) n_nxt = n_r + CTW'(1);
      end
      OP_P_FIN: begin
        trk_cnt_nxt = n_r;
        det_cnt_nxt = '0;
        taken_nxt   = '0;
      end
      OP_E_LD: begin
        t_nxt         = t_inc;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
    if (cmd.clr) begin
      t_nxt = '0;
      d_nxt = '0;
      n_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r          <= '0;
      d_r          <= '0;
      n_r          <= '0;
      trk_cnt_r    <= '0;
      det_cnt_r    <= '0;
      taken_r      <= '0;
      found_r      <= 1'b0;
      next_label_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      t_r          <= t_nxt;
      d_r          <= d_nxt;
      n_r          <= n_nxt;
      trk_cnt_r    <= trk_cnt_nxt;
      det_cnt_r    <= det_cnt_nxt;
      taken_r      <= taken_nxt;
      found_r      <= found_nxt;
      next_label_r <= next_label_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (det_we) det_mem[det_cnt_r[DIW-1:0]] <= det_wdata;
    det_rd_r <= det_mem[det_raddr];
    if (trk_we) trk_mem[trk_waddr] <= trk_wdata;
    trk_rd_r <= trk_mem[t_r[TIW-1:0]];
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_M_TLAT: begin
        tcur_r <= trk_rd_r;
        best_r <= '1;
      end
      OP_M_DIF: begin
        ex_r <= absdiff(centre2(tcur_r.x, tcur_r.w), centre2(det_rd_r.x, det_rd_r.w));
        ey_r <= absdiff(centre2(tcur_r.y, tcur_r.h), centre2(det_rd_r.y, det_rd_r.h));
      end
      OP_M_SQ: begin
        sqx_r <= 44'(ex_r) * 44'(ex_r);
        sqy_r <= 44'(ey_r) * 44'(ey_r);
      end
      OP_M_CMP: begin
        if (dist2 < best_r) begin
          best_r   <= dist2;
          best_d_r <= d_r[DIW-1:0];
        end
      end
      OP_O_LAT: begin
        dcur_r  <= det_rd_r;
        ox_r    <= overlap1d(tcur_r.x, tcur_r.w, det_rd_r.x, det_rd_r.w);
        oy_r    <= overlap1d(tcur_r.y, tcur_r.h, det_rd_r.y, det_rd_r.h);
        dispx_r <= {det_rd_r.x[19], det_rd_r.x} - {tcur_r.x[19], tcur_r.x};
        dispy_r <= {det_rd_r.y[19], det_rd_r.y} - {tcur_r.y[19], tcur_r.y};
      end
      OP_O_MUL: begin
        inter_r <= 38'(ox_r) * 38'(oy_r);
        at_r    <= 38'(tcur_r.w) * 38'(tcur_r.h);
        ad_r    <= 38'(dcur_r.w) * 38'(dcur_r.h);
      end
      OP_O_UNI: uni_r <= 39'(at_r) + 39'(ad_r) - 39'(inter_r);
      OP_O_THR: begin
        thu_r <= 48'(thr) * 48'(uni_r);
        uz_r  <= (uni_r == 39'd0);
      end
      OP_O_CMP: begin
        p1x_r <= $signed({{9{dispx_r[20]}}, dispx_r}) * EMA_NEW;
        p1y_r <= $signed({{9{dispy_r[20]}}, dispy_r}) * EMA_NEW;
        p2x_r <= $signed({{10{tcur_r.vx[19]}}, tcur_r.vx}) * EMA_OLD;
        p2y_r <= $signed({{10{tcur_r.vy[19]}}, tcur_r.vy}) * EMA_OLD;
      end
      OP_E_LD: begin
        out_r <= '{track_x: trk_rd_r.x, track_y: trk_rd_r.y,
                   track_width: trk_rd_r.w, track_height: trk_rd_r.h,
                   track_ident: trk_rd_r.label, last_track: (t_inc == trk_cnt_r)};
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `GBT_ASSERT_NEVER(a_trk_cnt, clk, rst_n, trk_cnt_r > CTW'(MAX_TRACKS))
  `GBT_ASSERT_NEVER(a_det_cnt, clk, rst_n, det_cnt_r > CDW'(MAX_DETS))
  `GBT_ASSERT_NEVER(a_out_load, clk, rst_n, (cmd.op == OP_E_LD) && out_valid_r)
  `GBT_ASSERT_IMPLY(a_accept_found, clk, rst_n, cmd.op == OP_A_EMA, found_r)

endmodule

>>> rtl/greedy_box_tracker.sv
// Greedy box tracker, top level: configuration registers, sequencer and
// datapath. Uses gbt_pkg, gbt_ctrl and gbt_datapath.
//
// Usage: send one request per detection on in_* (valid/ready). A request with
// frame_end set closes the frame (it may also carry a detection). Detections
// beyond MAX_DETS per frame are dropped. After frame_end the block predicts,
// matches, opens and prunes tracks, then emits every live track on out_* with
// last_track set on the final one; a frame with no tracks emits nothing.
// The match loop dominates the frame update: one shared distance unit
// compares every track with each untaken detection in turn. During
// emission the output register takes the next track once the previous one
// has been accepted or the register is empty.
// in_ready is low from frame_end until the last result has been loaded in the
// output register; a stalled receiver holds the block in the emit phase.
// Reset (rst_n low, synchronous) empties the detection and track tables,
// zeroes the identifier counter and restores overlap_threshold 77 and
// miss_limit 30. Write cfg_* only while the block is idle.
module greedy_box_tracker import gbt_pkg::*; #(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int MAX_DETS   = MAX_DETS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0] thr_r, thr_nxt;
  logic [7:0] limit_r, limit_nxt;
  cmd_t       cmd;
  status_t    sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    thr_nxt   = thr_r;
    limit_nxt = limit_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:  thr_nxt   = cfg_data;
        CFG_MISS_LIMIT: limit_nxt = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      limit_r <= LIMIT_RESET;
    end else begin
      thr_r   <= thr_nxt;
      limit_r <= limit_nxt;
    end
  end

  // sequencer: owns the phase, hands one command per cycle to the datapath
  gbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .frame_end (in_data.frame_end),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // datapath: stores, arithmetic and the result register
  gbt_datapath #(
    .MAX_TRACKS (MAX_TRACKS),
    .MAX_DETS   (MAX_DETS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .thr       (thr_r),
    .limit     (limit_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

endmodule

>>> verif/tb_greedy_box_tracker.sv
// Testbench for the greedy box tracker: loads frames of detections, predicts the
// track list each frame yields and checks every emitted track. Depends on gbt_pkg.
`timescale 1ns / 100ps

module tb_greedy_box_tracker import gbt_pkg::*; ();

  localparam int NTRK = 16;
  localparam int NDET = 32;
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  greedy_box_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow of the block's tables and registers.
  logic [8:0]  thr_q;
  logic [7:0]  lim_q;
  det_ent_t    dets [NDET];
  logic        taken [NDET];
  int          ndet;
  trk_ent_t    trks [NTRK];
  int          ntrk;
  logic [31:0] next_id;

  out_item_t   expected_tracks [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          sender_idle_on = 1'b1;
  bit          receiver_idle_on = 1'b1;
  bit          hold_receiver = 1'b0;
  int          hold_count = 0;
  int          rx_gap = 0;

  function automatic logic signed [19:0] clamp20(input longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic longint span1d(input longint a0, input longint al,
                                    input longint b0, input longint bl);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Round half up (floor of s/256 after +128), then clamp.
  function automatic logic signed [19:0] blend_velocity(input longint disp,
                                                        input longint vel);
    longint s;
    s = 179 * disp + 77 * vel + 128;
    return clamp20(s >>> 8);
  endfunction

  function automatic bit iou_passes(input trk_ent_t t, input det_ent_t d);
    longint inter, uni;
    inter = span1d(t.x, t.w, d.x, d.w) * span1d(t.y, t.h, d.y, d.h);
    uni = longint'(t.w) * t.h + longint'(d.w) * d.h - inter;
    if (uni == 0) return thr_q == 0;
    return inter * 256 >= longint'(thr_q) * uni;
  endfunction

  task automatic update_tracks(input in_item_t it);
    longint best, d2, ex, ey;
    int bd, n;
    out_item_t o;
    det_ent_t dd;
    if (it.is_detection && ndet < NDET) begin
      dets[ndet] = '{it.det_x, it.det_y, it.det_width, it.det_height};
      taken[ndet] = 1'b0;
      ndet++;
    end
    if (!it.frame_end) return;
    // predict
    for (int t = 0; t < ntrk; t++) begin
      trks[t].x = clamp20(longint'(trks[t].x) + trks[t].vx);
      trks[t].y = clamp20(longint'(trks[t].y) + trks[t].vy);
      if (trks[t].miss != 8'd255) trks[t].miss++;
    end
    // greedy nearest-centre match
    for (int t = 0; t < ntrk; t++) begin
      best = -1;
      bd = -1;
      for (int d = 0; d < ndet; d++) begin
        if (taken[d]) continue;
        ex = (2 * longint'(trks[t].x) + trks[t].w) - (2 * longint'(dets[d].x) + dets[d].w);
        ey = (2 * longint'(trks[t].y) + trks[t].h) - (2 * longint'(dets[d].y) + dets[d].h);
        d2 = ex * ex + ey * ey;
        if (bd < 0 || d2 < best) begin
          best = d2;
          bd = d;
        end
      end
      if (bd >= 0 && iou_passes(trks[t], dets[bd])) begin
        dd = dets[bd];
        trks[t].vx = blend_velocity(longint'(dd.x) - trks[t].x, trks[t].vx);
        trks[t].vy = blend_velocity(longint'(dd.y) - trks[t].y, trks[t].vy);
        trks[t].x = dd.x;
        trks[t].y = dd.y;
        trks[t].w = dd.w;
        trks[t].h = dd.h;
        trks[t].miss = '0;
        taken[bd] = 1'b1;
      end
    end
    // open new tracks
    for (int d = 0; d < ndet; d++) begin
      if (taken[d]) continue;
      if (ntrk >= NTRK) break;
      trks[ntrk] = '{dets[d].x, dets[d].y, dets[d].w, dets[d].h, 20'sd0, 20'sd0,
                     8'd0, next_id};
      next_id++;
      ntrk++;
    end
    // prune and compact
    n = 0;
    for (int t = 0; t < ntrk; t++) begin
      if (trks[t].miss > lim_q) continue;
      trks[n] = trks[t];
      n++;
    end
    ntrk = n;
    ndet = 0;
    for (int t = 0; t < ntrk; t++) begin
      o.track_x = trks[t].x;
      o.track_y = trks[t].y;
      o.track_width = trks[t].w;
      o.track_height = trks[t].h;
      o.track_ident = trks[t].label;
      o.last_track = (t == ntrk - 1);
      expected_tracks = {expected_tracks, o};
    end
  endtask

  // Hold valid until accepted; random gaps before some requests.
  task automatic send_request(input in_item_t it);
    int gap;
    cfg_valid <= 1'b0;
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    update_tracks(it);
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every result and for the block to go idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_tracks.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ready);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
    in_valid <= 1'b0;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_THRESHOLD) thr_q = val;
    else lim_q = val[7:0];
  endtask

  function automatic in_item_t make_det(input logic signed [19:0] x,
                                        input logic signed [19:0] y,
                                        input logic [18:0] w, input logic [18:0] h,
                                        input bit fe);
    in_item_t it;
    it.is_detection = 1'b1;
    it.frame_end = fe;
    it.det_x = x;
    it.det_y = y;
    it.det_width = w;
    it.det_height = h;
    return it;
  endfunction

  function automatic in_item_t close_only();
    in_item_t it;
    it = '0;
    it.frame_end = 1'b1;
    it.det_x = 20'($urandom);
    it.det_y = 20'($urandom);
    return it;
  endfunction

  // Box near a small cluster so tracks meet their detections again.
  function automatic in_item_t near_det(input int slot, input bit fe);
    int cx;
    cx = slot * 2000 - 8000;
    return make_det(20'(cx + $signed($urandom_range(0, 200)) - 100),
                    20'(cx / 2 + $signed($urandom_range(0, 200)) - 100),
                    19'($urandom_range(300, 900)), 19'($urandom_range(300, 900)), fe);
  endfunction

  function automatic in_item_t rand_det(input bit fe);
    return make_det(20'($urandom), 20'($urandom), 19'($urandom), 19'($urandom), fe);
  endfunction

  task automatic test_extremes();
    write_reg(CFG_THRESHOLD, 9'd77);
    write_reg(CFG_MISS_LIMIT, 9'd30);
    send_request(make_det(-20'sd524288, -20'sd524288, 19'h7ffff, 19'h7ffff, 1'b0));
    send_request(make_det(20'sd524287, 20'sd524287, 19'd0, 19'd0, 1'b0));
    send_request(make_det(20'sd0, 20'sd0, 19'd0, 19'd5, 1'b1));
    // both bits set with overlapping boxes
    send_request(make_det(-20'sd524288, -20'sd524288, 19'h7ffff, 19'h7ffff, 1'b1));
    // empty frame: tracks coast
    send_request(close_only());
    wait_drained();
    // empty union accepted only at threshold zero
    write_reg(CFG_THRESHOLD, 9'd0);
    send_request(make_det(20'sd0, 20'sd0, 19'd0, 19'd0, 1'b1));
    wait_drained();
    write_reg(CFG_THRESHOLD, 9'd511);
    send_request(make_det(20'sd10, 20'sd10, 19'd100, 19'd100, 1'b1));
    wait_drained();
    // remove everything quickly
    write_reg(CFG_MISS_LIMIT, 9'd0);
    send_request(close_only());
    send_request(close_only());
    wait_drained();
  endtask

  task automatic test_full_tables();
    write_reg(CFG_THRESHOLD, 9'd256);
    write_reg(CFG_MISS_LIMIT, 9'd254);
    // more than the detection table holds, tracks fill up too
    for (int i = 0; i < 35; i++) send_request(rand_det(i == 34));
    wait_drained();
  endtask

  task automatic test_backpressure();
    // receiver holds off for a counted stretch while the sender keeps going
    hold_receiver = 1'b1;
    for (int i = 0; i < 6; i++) send_request(near_det(i, i == 5));
    for (int i = 0; i < 4; i++) send_request(near_det(i, i == 3));
    hold_receiver = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_frames(input int n_items, input bit quiet);
    int sent, nd;
    sender_idle_on = !quiet;
    receiver_idle_on = !quiet;
    sent = 0;
    while (sent < n_items) begin
      nd = $urandom_range(0, 6);
      for (int i = 0; i <= nd; i++) begin
        case ($urandom_range(0, 9))
          0: send_request(rand_det(i == nd));
          1: send_request(close_only());
          default: send_request(near_det($urandom_range(0, 7), i == nd));
        endcase
        sent++;
      end
      if (!quiet && $urandom_range(0, 9) == 0) begin
        wait_drained();
        write_reg(CFG_THRESHOLD, 9'($urandom_range(0, 300)));
        write_reg(CFG_MISS_LIMIT, 9'($urandom_range(0, 6)));
      end
    end
    wait_drained();
  endtask

  // Receiver: random stall bursts, one long counted hold when asked.
  always @(posedge clk) begin
    if (!hold_receiver) hold_count <= 0;
    else if (hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
    if (rx_gap > 0) rx_gap <= rx_gap - 1;
    else if (receiver_idle_on && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 19);
    if (!rst_n || (hold_receiver && hold_count < HOLD_CYCLES) || rx_gap > 0)
      out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  // Checker: compare each accepted track with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tracks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected track %h", out_data);
      end else begin
        want = expected_tracks.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("track mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL greedy_box_tracker");
      $finish;
    end
  end

  initial begin
    thr_q = THR_RESET;
    lim_q = LIMIT_RESET;
    ndet = 0;
    ntrk = 0;
    next_id = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_full_tables();
    test_backpressure();
    write_reg(CFG_THRESHOLD, 9'd60);
    write_reg(CFG_MISS_LIMIT, 9'd3);
    test_random_frames(360, 1'b0);
    test_random_frames(55, 1'b1);
    if (mismatches == 0 && expected_tracks.size() == 0) $display("PASS greedy_box_tracker");
    else $display("FAIL greedy_box_tracker");
    $finish;
  end

endmodule

>>> greedy_box_tracker.f
+incdir+rtl
rtl/gbt_pkg.sv
rtl/gbt_ctrl.sv
rtl/gbt_datapath.sv
rtl/greedy_box_tracker.sv
verif/tb_greedy_box_tracker.sv
